// ----- rtl/grbf_pkg.sv -----
// Shared types, constants and the exponential table function for the Gaussian basis
// gradient accumulator. No dependencies.
package grbf_pkg;

  localparam int unsigned MUL_W = 33;
  localparam int unsigned PROD_W = 2 * MUL_W;
  localparam int unsigned ACC_W = 48;

  localparam logic [MUL_W-1:0] LOG2E_Q16 = 33'd94548;
  localparam logic [15:0] GAMMA_RESET = 16'd256;
  localparam longint unsigned LN2_Q32 = 64'd2977044472;
  localparam int unsigned SERIES_TERMS = 14;

  localparam logic signed [ACC_W-1:0] ACC_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [ACC_W-1:0] ACC_MIN = 48'sh8000_0000_0000;

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_SQ   = 9'b000000010,
    ST_GX   = 9'b000000100,
    ST_LG   = 9'b000001000,
    ST_EXP  = 9'b000010000,
    ST_DE   = 9'b000100000,
    ST_GP   = 9'b001000000,
    ST_DG   = 9'b010000000,
    ST_ACC  = 9'b100000000
  } state_t;

  // Truncating quotient by shift and subtract; only used while the table constants are built.
  function automatic longint unsigned div_small(input longint unsigned num,
                                                input int unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= 64'(den)) begin
        rem = rem - 64'(den);
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Table entry j holds 2^(-j / 2^bits) in Q0.16, from a series in Q0.32.
  function automatic logic [15:0] rom_entry(input int unsigned j, input int unsigned bits);
    longint unsigned u;
    longint unsigned sum;
    longint unsigned term;
    u = (longint'(j) * LN2_Q32) >> bits;
    sum = 64'd1 << 32;
    term = 64'd1 << 32;
    for (int unsigned n = 1; n <= SERIES_TERMS; n++) begin
      term = (term * u) >> 32;
      term = div_small(term, n);
      if (n[0]) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    sum = (sum + 64'h8000) >> 16;
    if (sum > 64'hFFFF) begin
      sum = 64'hFFFF;
    end
    return sum[15:0];
  endfunction

endpackage

// ----- rtl/gaussian_rbf_gradient_accumulate.sv -----
// Gaussian basis gradient accumulator, top level. Depends on grbf_pkg, grbf_mul, grbf_exp_rom.
// A word is accepted in the idle state, then in_tready stays low while the sequencer does six
// products on the shared 33x33 multiplier, a table lookup and an accumulate step; no new word is
// taken before the last is through. A row result is registered by the accumulate step of its last
// word, later only while the previous result still waits on out_tready. Synchronous active-low
// reset clears the sequencer, the row sum and the output valid, and sets the width factor to 1.0.
module gaussian_rbf_gradient_accumulate #(
  parameter int unsigned EXP_TABLE_BITS = 6
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,   // gaussian_width
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,      // distance, center, upstream_grad
  input  logic        in_tlast,      // last_term
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata      // grad_r
);

  grbf_pkg::state_t state_r, state_nxt;

  logic [15:0]                              gamma_r;
  logic signed [16:0]                       delta_r;
  logic signed [31:0]                       g_r;
  logic                                     last_r;
  logic [15:0]                              e_r;
  logic [15:0]                              e_nxt;
  logic signed [grbf_pkg::ACC_W-1:0]        acc_r, acc_nxt;
  logic [grbf_pkg::ACC_W-1:0]               out_data_r, out_data_nxt;
  logic                                     out_valid_r, out_valid_nxt;
  logic signed [grbf_pkg::MUL_W-1:0]        mul_a, mul_b;
  logic                                     mul_en;
  logic signed [grbf_pkg::PROD_W-1:0]       prod;
  logic signed [49:0]                       term;
  logic signed [50:0]                       sum;
  logic signed [grbf_pkg::ACC_W-1:0]        sat;
  logic                                     out_blocked;

  grbf_mul u_mul (
    .clk    (clk),
    .en     (mul_en),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod)
  );

  grbf_exp_rom #(
    .TABLE_BITS (EXP_TABLE_BITS)
  ) u_exp (
    .y (prod[48:16]),
    .e (e_nxt)
  );

  assign in_tready   = (state_r == grbf_pkg::ST_IDLE);
  assign out_tvalid  = out_valid_r;
  assign out_tdata   = out_data_r;
  assign out_blocked = out_valid_r && !out_tready;

  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b1;
    unique case (state_r)
      grbf_pkg::ST_SQ: begin
        mul_a = {{16{delta_r[16]}}, delta_r};
        mul_b = {{16{delta_r[16]}}, delta_r};
      end
      grbf_pkg::ST_GX: begin
        mul_a = {17'b0, gamma_r};
        mul_b = {1'b0, prod[31:0]};
      end
      grbf_pkg::ST_LG: begin
        mul_a = {1'b0, prod[47:16]};
        mul_b = grbf_pkg::LOG2E_Q16;
      end
      grbf_pkg::ST_DE: begin
        mul_a = {{16{delta_r[16]}}, delta_r};
        mul_b = {17'b0, e_r};
      end
      grbf_pkg::ST_GP: begin
        mul_a = -$signed({17'b0, gamma_r});
        mul_b = prod[32:0];
      end
      grbf_pkg::ST_DG: begin
        mul_a = {{2{prod[49]}}, prod[49:19]};
        mul_b = {g_r[31], g_r};
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  assign term = prod[65:16];
  assign sum  = {{3{acc_r[47]}}, acc_r} + {term[49], term};

  always_comb begin
    if (sum[50:47] == 4'b0000 || sum[50:47] == 4'b1111) begin
      sat = sum[47:0];
    end else if (sum[50]) begin
      sat = grbf_pkg::ACC_MIN;
    end else begin
      sat = grbf_pkg::ACC_MAX;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    acc_nxt       = acc_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_tready;
    unique case (state_r)
      grbf_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = grbf_pkg::ST_SQ;
        end
      end
      grbf_pkg::ST_SQ:  state_nxt = grbf_pkg::ST_GX;
      grbf_pkg::ST_GX:  state_nxt = grbf_pkg::ST_LG;
      grbf_pkg::ST_LG:  state_nxt = grbf_pkg::ST_EXP;
      grbf_pkg::ST_EXP: state_nxt = grbf_pkg::ST_DE;
      grbf_pkg::ST_DE:  state_nxt = grbf_pkg::ST_GP;
      grbf_pkg::ST_GP:  state_nxt = grbf_pkg::ST_DG;
      grbf_pkg::ST_DG:  state_nxt = grbf_pkg::ST_ACC;
      grbf_pkg::ST_ACC: begin
        if (!last_r) begin
          acc_nxt   = sat;
          state_nxt = grbf_pkg::ST_IDLE;
        end else if (!out_blocked) begin
          acc_nxt       = '0;
          out_data_nxt  = sat;
          out_valid_nxt = 1'b1;
          state_nxt     = grbf_pkg::ST_IDLE;
        end
      end
      default: state_nxt = grbf_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= grbf_pkg::ST_IDLE;
      gamma_r     <= grbf_pkg::GAMMA_RESET;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        gamma_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (in_tvalid && in_tready) begin
      delta_r <= $signed({1'b0, in_tdata[15:0]}) - $signed({1'b0, in_tdata[31:16]});
      g_r     <= in_tdata[63:32];
      last_r  <= in_tlast;
    end
    if (state_r == grbf_pkg::ST_EXP) begin
      e_r <= e_nxt;
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == grbf_pkg::ST_SQ) && !in_tready)
    else $error("accepted word did not start the sequencer");

  a_row_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == grbf_pkg::ST_ACC && last_r && !out_blocked) |=> (acc_r == '0) && out_valid_r)
    else $error("row end did not emit and clear the row sum");

  a_no_spurious_out: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid_r && !(state_r == grbf_pkg::ST_ACC && last_r)) |=> !out_valid_r)
    else $error("result raised without a last word");

  a_prod_held_acc: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == grbf_pkg::ST_ACC && $past(state_r == grbf_pkg::ST_ACC)) |-> $stable(prod))
    else $error("product changed while waiting to accumulate");

endmodule

// ----- rtl/grbf_mul.sv -----
// Shared signed multiplier with a registered product.
// Depends on grbf_pkg for the operand width.
module grbf_mul (
  input  logic                                   clk,
  input  logic                                   en,
  input  logic signed [grbf_pkg::MUL_W-1:0]      a,
  input  logic signed [grbf_pkg::MUL_W-1:0]      b,
  output logic signed [grbf_pkg::PROD_W-1:0]     prod_r
);

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= a * b;
    end
  end

endmodule

// ----- rtl/grbf_exp_rom.sv -----
// Exponential table with base-2 range reduction: maps y (Q.16 log2 exponent) to 2^-y.
// Depends on grbf_pkg for the table contents.
module grbf_exp_rom #(
  parameter int unsigned TABLE_BITS = 6
) (
  input  logic [32:0] y,
  output logic [15:0] e
);

  logic [15:0]           rom_tbl [2**TABLE_BITS];
  logic [TABLE_BITS-1:0] idx;
  logic [16:0]           k;

  for (genvar i = 0; i < 2**TABLE_BITS; i++) begin : g_tbl
    localparam logic [15:0] ENTRY = grbf_pkg::rom_entry(i, TABLE_BITS);
    assign rom_tbl[i] = ENTRY;
  end

  assign idx = y[15 -: TABLE_BITS];
  assign k   = y[32:16];
  assign e   = (|k[16:4]) ? 16'd0 : (rom_tbl[idx] >> k[3:0]);

endmodule

// ----- tb/gaussian_rbf_gradient_accumulate_tb.sv -----
// Self-checking testbench for the Gaussian basis gradient accumulator: directed rows,
// zero width, large full-rate rows and random rows under random stalls on none, one or both streams.
// Depends on grbf_pkg and the gaussian_rbf_gradient_accumulate RTL.
module gaussian_rbf_gradient_accumulate_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned EXP_BITS = 6;
  localparam int DRAIN_CYCLES = 16;
  localparam int BIG_TERMS = 24;
  localparam int PHASE_TERMS = 300;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;   // distance, center, upstream_grad
  logic        in_tlast;   // last_term
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;  // grad_r

  logic [15:0] model_width;
  longint      model_row_sum;
  logic [47:0] row_sum_expected[$];

  int send_gap_max;
  int ready_stall_max;
  int mismatches;
  int rows_checked;
  int terms_sent;
  int width_writes;

  gaussian_rbf_gradient_accumulate #(
    .EXP_TABLE_BITS(EXP_BITS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tlast(in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [15:0] exp2_frac_q16(input int unsigned idx);
    longint unsigned u;
    longint unsigned total;
    longint unsigned t;
    u = (64'(idx) * grbf_pkg::LN2_Q32) >> EXP_BITS;
    total = 64'd1 << 32;
    t = 64'd1 << 32;
    for (int unsigned n = 1; n <= grbf_pkg::SERIES_TERMS; n++) begin
      t = (t * u) >> 32;
      t = t / n;
      if (n % 2 == 1) begin
        total = total - t;
      end else begin
        total = total + t;
      end
    end
    total = (total + 64'h8000) >> 16;
    if (total > 64'hFFFF) begin
      total = 64'hFFFF;
    end
    return total[15:0];
  endfunction

  function automatic void predict_term(input logic [15:0] r, input logic [15:0] c,
                                       input logic signed [31:0] g, input logic last);
    longint delta;
    longint mag;
    longint x;
    longint y;
    longint k;
    longint e;
    longint df;
    longint term;
    longint acc;
    longint grad;
    int unsigned idx;
    delta = $signed({48'd0, r}) - $signed({48'd0, c});
    mag = (delta < 0) ? -delta : delta;
    x = ($signed({48'd0, model_width}) * (mag * mag)) >>> 16;
    y = (x * $signed({31'd0, grbf_pkg::LOG2E_Q16})) >>> 16;
    k = y >>> 16;
    idx = y[15:16-EXP_BITS];
    if (k >= 16) begin
      e = 0;
    end else begin
      e = {48'd0, exp2_frac_q16(idx)} >> k;
    end
    df = (-(2 * $signed({48'd0, model_width}) * delta * e)) >>> 20;
    grad = g;
    term = (df * grad) >>> 16;
    acc = model_row_sum + term;
    if (acc > longint'(grbf_pkg::ACC_MAX)) begin
      acc = grbf_pkg::ACC_MAX;
    end
    if (acc < longint'(grbf_pkg::ACC_MIN)) begin
      acc = grbf_pkg::ACC_MIN;
    end
    model_row_sum = acc;
    if (last) begin
      row_sum_expected.push_back(acc[47:0]);
      model_row_sum = 0;
    end
  endfunction

  function automatic logic [31:0] pick_grad();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'($urandom_range(0, 1 << 17)) - 32'h0001_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_term(input logic [15:0] r, input logic [15:0] c,
                           input logic [31:0] g, input logic last);
    int gap;
    gap = $urandom_range(0, send_gap_max);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {g, c, r};
    in_tlast <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_term(r, c, g, last);
    terms_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (row_sum_expected.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_width(input logic [15:0] value);
    wait_drained();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    model_width = value;
    width_writes++;
  endtask

  // Receiver: per result, hold tready low for a random number of cycles.
  initial begin
    int stall;
    @(negedge clk);
    forever begin
      stall = $urandom_range(0, ready_stall_max);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!(out_tvalid && out_tready)) @(posedge clk);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (row_sum_expected.size() == 0) begin
        $display("%0t: unexpected row sum, expected none, actual %0d", $time,
                 $signed(out_tdata));
        mismatches++;
      end else begin
        if (out_tdata !== row_sum_expected[0]) begin
          $display("%0t: grad_r mismatch, expected %0d, actual %0d", $time,
                   $signed(row_sum_expected[0]), $signed(out_tdata));
          mismatches++;
        end
        void'(row_sum_expected.pop_front());
        rows_checked++;
      end
    end
  end

  task automatic test_directed();
    send_term(16'd0, 16'd0, 32'h7FFF_FFFF, 1'b1);
    send_term(16'hFFFF, 16'd0, 32'h8000_0000, 1'b1);
    send_term(16'd0, 16'hFFFF, 32'h7FFF_FFFF, 1'b1);
    send_term(16'hFFFF, 16'hFFFF, 32'h8000_0000, 1'b1);
    send_term(16'd4096, 16'd3072, 32'h0001_0000, 1'b0);
    send_term(16'd4096, 16'd5120, 32'hFFFF_0000, 1'b0);
    send_term(16'd4096, 16'd4196, 32'h7FFF_FFFF, 1'b1);
    send_term(16'd2048, 16'd2000, 32'hFFFF_FFFF, 1'b1);
    send_term(16'd2000, 16'd2048, 32'h0000_0001, 1'b1);
    write_width(16'hFFFF);
    send_term(16'd181, 16'd0, 32'h8000_0000, 1'b1);
    send_term(16'd0, 16'd181, 32'h7FFF_FFFF, 1'b1);
    send_term(16'hFFFF, 16'hFFFE, 32'h8000_0000, 1'b0);
    send_term(16'hFFFE, 16'hFFFF, 32'h8000_0000, 1'b1);
    write_width(16'd1);
    send_term(16'hFFFF, 16'd0, 32'h7FFF_FFFF, 1'b0);
    send_term(16'd0, 16'hFFFF, 32'h8000_0000, 1'b1);
    send_term(16'd30000, 16'd100, 32'h1234_5678, 1'b1);
  endtask

  task automatic test_zero_width();
    write_width(16'd0);
    for (int i = 0; i < 8; i++) begin
      send_term(16'($urandom), 16'($urandom), pick_grad(), (i % 2 == 1));
    end
  endtask

  task automatic test_large_rows();
    send_gap_max = 0;
    ready_stall_max = 0;
    write_width(16'hFFFF);
    for (int i = 0; i < BIG_TERMS; i++) begin
      send_term(16'd181, 16'd0, 32'h8000_0000, (i == BIG_TERMS - 1));
    end
    for (int i = 0; i < BIG_TERMS; i++) begin
      send_term(16'd0, 16'd181, 32'h8000_0000, 1'b0);
    end
    for (int i = 0; i < 3; i++) begin
      send_term(16'd181, 16'd0, 32'h8000_0000, (i == 2));
    end
  endtask

  task automatic test_random();
    logic [15:0] widths[6];
    logic [15:0] r;
    logic [15:0] c;
    int len;
    int sent;
    bit noisy;
    widths = '{16'hFFFF, 16'h0000, 16'($urandom), 16'd1, 16'($urandom_range(1, 1024)),
               16'($urandom)};
    for (int phase = 0; phase < 6; phase++) begin
      send_gap_max = (phase == 2 || phase == 4) ? 0 : 16;
      ready_stall_max = (phase == 2 || phase == 5) ? 0 : 16;
      write_width(widths[phase]);
      sent = 0;
      while (sent < PHASE_TERMS) begin
        if (phase == 3 && sent >= PHASE_TERMS / 2 && sent < PHASE_TERMS / 2 + 12) begin
          wait_drained();
        end
        len = $urandom_range(1, 12);
        noisy = ($urandom_range(0, 7) == 0);
        r = 16'($urandom);
        for (int i = 0; i < len; i++) begin
          if (noisy) begin
            r = 16'($urandom);
          end
          if (!noisy && $urandom_range(0, 3) != 0) begin
            c = r + 16'($urandom_range(0, 1023)) - 16'd512;
          end else begin
            c = 16'($urandom);
          end
          send_term(r, c, pick_grad(), (i == len - 1));
        end
        sent += len;
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    model_width = grbf_pkg::GAMMA_RESET;
    model_row_sum = 0;
    send_gap_max = 16;
    ready_stall_max = 16;
    mismatches = 0;
    rows_checked = 0;
    terms_sent = 0;
    width_writes = 0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_zero_width();
    test_large_rows();
    test_random();
    wait_drained();

    $display("Sent %0d basis terms and checked %0d row sums across %0d width settings,",
             terms_sent, rows_checked, width_writes + 1);
    $display("with zero and full-scale widths, large full-rate rows and random stalls.");
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("Timeout with %0d row sums still outstanding.", row_sum_expected.size());
    $display("Verification failed");
    $finish;
  end

endmodule
